// File: src/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg: shared types and constants of the pixel nonlinearity correction
// Item commands, multiply sequencer step codes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pnc_pkg;

    // Item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Multiplier A operand selects
    localparam logic [2:0] A_MV  = 3'd0;
    localparam logic [2:0] A_RS0 = 3'd1;
    localparam logic [2:0] A_RS1 = 3'd2;
    localparam logic [2:0] A_RC0 = 3'd3;
    localparam logic [2:0] A_RC1 = 3'd4;

    // Multiplier B operand selects
    localparam logic [2:0] B_MV   = 3'd0;
    localparam logic [2:0] B_M2_0 = 3'd1;
    localparam logic [2:0] B_M2_1 = 3'd2;
    localparam logic [2:0] B_M3_0 = 3'd3;
    localparam logic [2:0] B_M3_1 = 3'd4;
    localparam logic [2:0] B_M3_2 = 3'd5;

    // Product destinations
    localparam logic [2:0] D_NONE   = 3'd0;
    localparam logic [2:0] D_M2     = 3'd1;
    localparam logic [2:0] D_M3_SET = 3'd2;
    localparam logic [2:0] D_M3_ADD = 3'd3;
    localparam logic [2:0] D_ACC    = 3'd4;

    // Which correction term an accumulator product belongs to
    localparam logic TERM_SQ = 1'b0;
    localparam logic TERM_CU = 1'b1;

    localparam int MAC_STEPS = 15;
    localparam int STEP_W    = 4;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] dest;
        logic [1:0] limb;
        logic       term;
    } t_mac_cmd;

    localparam t_mac_cmd MAC_NOP = '{A_MV, B_MV, D_NONE, 2'd0, TERM_SQ};

    typedef struct packed {
        logic     latch;
        logic     div_start;
        logic     div_sel_c;
        logic     store_sq;
        logic     store_cu;
        t_mac_cmd mac;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

    // Schedule of the sample computation. The square is formed first, then
    // the cube, then the partial products of both correction terms. One idle
    // step lets the square settle, and the last one drains the product stage.
    function automatic t_mac_cmd mac_step(input logic [STEP_W-1:0] step);
        t_mac_cmd m;
        m = MAC_NOP;
        case (step)
            4'd0:    m = '{A_MV,  B_MV,   D_M2,     2'd0, TERM_SQ};
            4'd2:    m = '{A_MV,  B_M2_0, D_M3_SET, 2'd0, TERM_SQ};
            4'd3:    m = '{A_MV,  B_M2_1, D_M3_ADD, 2'd1, TERM_SQ};
            4'd4:    m = '{A_RS0, B_M2_0, D_ACC,    2'd0, TERM_SQ};
            4'd5:    m = '{A_RS0, B_M2_1, D_ACC,    2'd1, TERM_SQ};
            4'd6:    m = '{A_RS1, B_M2_0, D_ACC,    2'd1, TERM_SQ};
            4'd7:    m = '{A_RS1, B_M2_1, D_ACC,    2'd2, TERM_SQ};
            4'd8:    m = '{A_RC0, B_M3_0, D_ACC,    2'd0, TERM_CU};
            4'd9:    m = '{A_RC0, B_M3_1, D_ACC,    2'd1, TERM_CU};
            4'd10:   m = '{A_RC0, B_M3_2, D_ACC,    2'd2, TERM_CU};
            4'd11:   m = '{A_RC1, B_M3_0, D_ACC,    2'd1, TERM_CU};
            4'd12:   m = '{A_RC1, B_M3_1, D_ACC,    2'd2, TERM_CU};
            4'd13:   m = '{A_RC1, B_M3_2, D_ACC,    2'd3, TERM_CU};
            default: m = MAC_NOP;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: src/pixel_nonlinearity_correction_core.sv
// ----------------------------------------------------------------------------
// pixel_nonlinearity_correction_core: cubic detector linearity correction
// An input item with i_cmd = load carries a pixel's coefficients a, b and c;
// the block stores b/a and c/a as fixed-point ratios and gives no result.
// An item with i_cmd = sample returns one result on o_corrected/o_clipped:
// v + (b/a)*v^2 + (c/a)*v^3, rounded half up and saturated to the sample
// range, with o_clipped high when saturation took place.
// Both channels use valid/ready; an item moves when valid and ready are high.
// A load runs one bit-serial divider, which produces one quotient bit per
// cycle, once for each ratio. For a sample, a single 32x32 multiplier works
// through the square, the cube and 10 partial products of the two correction
// terms. No new item is accepted until the current one is done.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when the following result is ready,
// the block holds that result internally until the register frees up.
// Reset clears both ratios to zero, so a sample before any load passes
// through unchanged, and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_nonlinearity_correction_core
    import pnc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 24,
    parameter int SQUARE_FRAC_BITS = 32,
    parameter int CUBE_FRAC_BITS   = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_cmd,
    input  wire logic signed [31:0]            i_coef_a,
    input  wire logic signed [31:0]            i_coef_b,
    input  wire logic signed [31:0]            i_coef_c,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_corrected,
    output logic                               o_clipped
);

    t_dp_cmd    s_dp_cmd;
    t_dp_status s_dp_status;

    pnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_dp_cmd    (s_dp_cmd),
        .i_dp_status (s_dp_status)
    );

    pnc_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SQUARE_FRAC_BITS (SQUARE_FRAC_BITS),
        .CUBE_FRAC_BITS   (CUBE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_dp_cmd),
        .o_status    (s_dp_status),
        .i_coef_a    (i_coef_a),
        .i_coef_b    (i_coef_b),
        .i_coef_c    (i_coef_c),
        .i_sample    (i_sample),
        .o_corrected (o_corrected),
        .o_clipped   (o_clipped)
    );

    // A new result is never written over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_dp_cmd.out_load |-> (!o_valid || i_ready))
        else $error("result register overwritten while still holding an item");

    // Once an item is taken, the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready again right after accepting an item");

    // A load item produces no result.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_cmd == CMD_LOAD)) |=> !$rose(o_valid))
        else $error("result appeared after a load item");

endmodule

`default_nettype wire

// File: src/pnc_div.sv
// ----------------------------------------------------------------------------
// pnc_div: bit-serial unsigned divider
// Restoring division of a wide numerator by a 32-bit divisor, one quotient
// bit per cycle. The quotient stays on o_quot after the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_div #(
    parameter int DIV_W = 80
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [31:0]      i_den,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;
    logic [DIV_W-1:0] r_num;

    logic [32:0]      w_trial;
    logic             w_ge;
    logic [32:0]      w_diff;

    always_comb begin
        w_trial = {r_rem, r_num[DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The numerator register shifts out dividend bits and takes in quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: src/pnc_dp.sv
// ----------------------------------------------------------------------------
// pnc_dp: datapath of the pixel nonlinearity correction
// Holds the item registers, the two stored ratios, the serial divider, a
// shared 32x32 multiplier with a registered product, the wide accumulator
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_dp
    import pnc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 24,
    parameter int SQUARE_FRAC_BITS = 32,
    parameter int CUBE_FRAC_BITS   = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_status                         o_status,
    input  wire logic signed [31:0]            i_coef_a,
    input  wire logic signed [31:0]            i_coef_b,
    input  wire logic signed [31:0]            i_coef_c,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0]      o_corrected,
    output logic                               o_clipped
);

    localparam int SB      = SAMPLE_BITS;
    localparam int MAXF    = (SQUARE_FRAC_BITS > CUBE_FRAC_BITS) ?
                             SQUARE_FRAC_BITS : CUBE_FRAC_BITS;
    localparam int MINF    = (SQUARE_FRAC_BITS < CUBE_FRAC_BITS) ?
                             SQUARE_FRAC_BITS : CUBE_FRAC_BITS;
    localparam int DIV_W   = 32 + MAXF;
    localparam int QX_W    = (DIV_W > 65) ? DIV_W : 65;
    localparam int ACC_W   = 66 + 3 * SB + MAXF - MINF;
    localparam int SHAMT_W = $clog2(96 + MAXF - MINF + 1);
    localparam int OFF_SQ  = MAXF - SQUARE_FRAC_BITS;
    localparam int OFF_CU  = MAXF - CUBE_FRAC_BITS;
    localparam int HI_LSB  = MAXF + SB - 1;

    localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (MAXF - 1);
    localparam logic [63:0]      LIM_POS    = {1'b0, {63{1'b1}}};
    localparam logic [63:0]      LIM_NEG    = {1'b1, {63{1'b0}}};
    localparam logic [SB-1:0]    SAT_HI     = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]    SAT_LO     = {1'b1, {(SB-1){1'b0}}};

    // Item registers
    logic [31:0]      r_a_mag, r_b_mag, r_c_mag;
    logic             r_a_neg, r_b_neg, r_c_neg;
    logic [SB-1:0]    r_mv;
    logic             r_v_neg;

    // Stored ratios in sign and magnitude form
    logic [63:0]      r_sq_mag, r_cu_mag;
    logic             r_sq_neg, r_cu_neg;

    // Multiply sequence
    logic [63:0]      r_m2;
    logic [95:0]      r_m3;
    logic [63:0]      r_p;
    t_mac_cmd         r_p_cmd;
    logic [ACC_W-1:0] r_acc;

    logic [SB-1:0]    r_corrected;
    logic             r_clipped;

    logic [DIV_W-1:0] w_num;
    logic [DIV_W-1:0] w_quot;
    logic             w_div_done;
    logic [QX_W-1:0]  w_qx;
    logic             w_q_neg;
    logic             w_over;
    logic [63:0]      w_q_mag;

    logic [31:0]      w_op_a, w_op_b;
    logic [63:0]      w_prod;
    logic [SHAMT_W-1:0] w_shamt;
    logic [ACC_W-1:0] w_pp;
    logic             w_pp_neg;
    logic [ACC_W-1:0] w_acc_next;
    logic [ACC_W-1:0] w_acc_init;

    logic [ACC_W-HI_LSB-1:0] w_int_hi;
    logic             w_fits;
    logic [SB-1:0]    w_res;

    // ------------------------------------------------------------------ divider
    assign w_num = i_cmd.div_sel_c ? (DIV_W'(r_c_mag) << CUBE_FRAC_BITS)
                                   : (DIV_W'(r_b_mag) << SQUARE_FRAC_BITS);

    pnc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_a_mag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_status.div_done = w_div_done;

    // A negative quotient may reach 2^63; a positive one stops one short.
    always_comb begin
        w_qx    = QX_W'(w_quot);
        w_q_neg = i_cmd.store_cu ? (r_c_neg ^ r_a_neg) : (r_b_neg ^ r_a_neg);
        if (w_q_neg) begin
            w_over = (|w_qx[QX_W-1:64]) || (w_qx[63] && (|w_qx[62:0]));
        end else begin
            w_over = |w_qx[QX_W-1:63];
        end
        if (r_a_mag == 32'd0) begin
            w_q_mag = '0;
        end else if (w_over) begin
            w_q_mag = w_q_neg ? LIM_NEG : LIM_POS;
        end else begin
            w_q_mag = w_qx[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_mag <= '0;
            r_sq_neg <= 1'b0;
            r_cu_mag <= '0;
            r_cu_neg <= 1'b0;
        end else begin
            if (i_cmd.store_sq) begin
                r_sq_mag <= w_q_mag;
                r_sq_neg <= w_q_neg;
            end
            if (i_cmd.store_cu) begin
                r_cu_mag <= w_q_mag;
                r_cu_neg <= w_q_neg;
            end
        end
    end

    // ------------------------------------------------------------ item capture
    // The sample enters the accumulator already scaled, with the rounding half.
    assign w_acc_init = ({{(ACC_W-SB){i_sample[SB-1]}}, i_sample} << MAXF) | ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_a_mag <= i_coef_a[31] ? (~i_coef_a + 32'sd1) : i_coef_a;
            r_b_mag <= i_coef_b[31] ? (~i_coef_b + 32'sd1) : i_coef_b;
            r_c_mag <= i_coef_c[31] ? (~i_coef_c + 32'sd1) : i_coef_c;
            r_a_neg <= i_coef_a[31];
            r_b_neg <= i_coef_b[31];
            r_c_neg <= i_coef_c[31];
            r_mv    <= i_sample[SB-1] ? (~i_sample + SB'(1)) : i_sample;
            r_v_neg <= i_sample[SB-1];
        end
    end

    // ------------------------------------------------------------ product stage
    always_comb begin
        case (i_cmd.mac.a_sel)
            A_MV:    w_op_a = 32'(r_mv);
            A_RS0:   w_op_a = r_sq_mag[31:0];
            A_RS1:   w_op_a = r_sq_mag[63:32];
            A_RC0:   w_op_a = r_cu_mag[31:0];
            A_RC1:   w_op_a = r_cu_mag[63:32];
            default: w_op_a = '0;
        endcase
        case (i_cmd.mac.b_sel)
            B_MV:    w_op_b = 32'(r_mv);
            B_M2_0:  w_op_b = r_m2[31:0];
            B_M2_1:  w_op_b = r_m2[63:32];
            B_M3_0:  w_op_b = r_m3[31:0];
            B_M3_1:  w_op_b = r_m3[63:32];
            B_M3_2:  w_op_b = r_m3[95:64];
            default: w_op_b = '0;
        endcase
        w_prod = w_op_a * w_op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_cmd <= MAC_NOP;
        end else begin
            r_p_cmd <= i_cmd.mac;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
    end

    // --------------------------------------------------------- accumulate stage
    always_comb begin
        w_shamt    = SHAMT_W'({r_p_cmd.limb, 5'b0}) +
                     ((r_p_cmd.term == TERM_CU) ? SHAMT_W'(OFF_CU) : SHAMT_W'(OFF_SQ));
        w_pp       = ACC_W'(r_p) << w_shamt;
        w_pp_neg   = (r_p_cmd.term == TERM_CU) ? (r_cu_neg ^ r_v_neg) : r_sq_neg;
        w_acc_next = w_pp_neg ? (r_acc - w_pp) : (r_acc + w_pp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_acc <= w_acc_init;
        end else if (r_p_cmd.dest == D_ACC) begin
            r_acc <= w_acc_next;
        end
        case (r_p_cmd.dest)
            D_M2:     r_m2 <= r_p;
            D_M3_SET: r_m3 <= 96'(r_p);
            D_M3_ADD: r_m3 <= r_m3 + (96'(r_p) << {r_p_cmd.limb, 5'b0});
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------ result
    // The integer part fits when every bit from the sample's sign bit up agrees.
    always_comb begin
        w_int_hi = r_acc[ACC_W-1:HI_LSB];
        w_fits   = (&w_int_hi) || !(|w_int_hi);
        if (w_fits) begin
            w_res = r_acc[HI_LSB:MAXF];
        end else begin
            w_res = r_acc[ACC_W-1] ? SAT_LO : SAT_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_corrected <= w_res;
            r_clipped   <= !w_fits;
        end
    end

    assign o_corrected = r_corrected;
    assign o_clipped   = r_clipped;

endmodule

`default_nettype wire

// File: src/pnc_ctrl.sv
// ----------------------------------------------------------------------------
// pnc_ctrl: controller of the pixel nonlinearity correction
// Accepts items, runs the two ratio divisions of a load or the multiply
// schedule of a sample, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_ctrl
    import pnc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_cmd,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_dp_cmd,
    input  wire t_dp_status i_dp_status
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_B_GO  = 3'd1;
    localparam logic [2:0] S_DIV_B_RUN = 3'd2;
    localparam logic [2:0] S_DIV_C_GO  = 3'd3;
    localparam logic [2:0] S_DIV_C_RUN = 3'd4;
    localparam logic [2:0] S_MUL       = 3'd5;
    localparam logic [2:0] S_RES       = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp_cmd    = '0;
        o_dp_cmd.mac = MAC_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.latch = 1'b1;
                    n_step         = '0;
                    n_state        = (i_cmd == CMD_LOAD) ? S_DIV_B_GO : S_MUL;
                end
            end
            S_DIV_B_GO: begin
                o_dp_cmd.div_start = 1'b1;
                n_state            = S_DIV_B_RUN;
            end
            S_DIV_B_RUN: begin
                if (i_dp_status.div_done) begin
                    o_dp_cmd.store_sq = 1'b1;
                    n_state           = S_DIV_C_GO;
                end
            end
            S_DIV_C_GO: begin
                o_dp_cmd.div_start = 1'b1;
                o_dp_cmd.div_sel_c = 1'b1;
                n_state            = S_DIV_C_RUN;
            end
            S_DIV_C_RUN: begin
                if (i_dp_status.div_done) begin
                    o_dp_cmd.store_cu = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_MUL: begin
                o_dp_cmd.mac = mac_step(r_step);
                if (r_step == STEP_W'(MAC_STEPS - 1)) begin
                    n_state = S_RES;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_RES: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sim/pnc_checker.sv
// ----------------------------------------------------------------------------
// pnc_checker: result checker for the pixel nonlinearity correction core
// Watches both channels of the core. Each accepted load updates a private
// copy of the two coefficient ratios, and each accepted sample queues the
// corrected value and clip flag that the core must return. Every returned
// item is compared with the oldest queued one, and failures are counted.
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_checker
    import pnc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 24,
    parameter int SQUARE_FRAC_BITS = 32,
    parameter int CUBE_FRAC_BITS   = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic signed [31:0]            i_coef_a,
    input  wire logic signed [31:0]            i_coef_b,
    input  wire logic signed [31:0]            i_coef_c,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_corrected,
    input  wire logic                          i_clipped,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_clips
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_FRAC = (SQUARE_FRAC_BITS > CUBE_FRAC_BITS) ?
                              SQUARE_FRAC_BITS : CUBE_FRAC_BITS;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [127:0] RATIO_HI = (128'sd1 <<< 63) - 128'sd1;
    localparam logic signed [127:0] RATIO_LO = -(128'sd1 <<< 63);
    localparam logic signed [255:0] PIX_HI   = (256'sd1 <<< (SAMPLE_BITS - 1)) - 256'sd1;
    localparam logic signed [255:0] PIX_LO   = -(256'sd1 <<< (SAMPLE_BITS - 1));

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] corrected;
        logic                          clipped;
    } t_pixel_fix;

    t_pixel_fix        pending_fixes[$];
    logic signed [63:0] quad_ratio;
    logic signed [63:0] cubic_ratio;

    // Quotient of num * 2^frac by den, truncated toward zero and clamped to
    // the signed 64 bit range. A zero denominator gives a zero ratio.
    function automatic logic signed [63:0] fixed_ratio(input logic signed [31:0] num,
                                                       input logic signed [31:0] den,
                                                       input int frac);
        logic signed [127:0] wide_num;
        logic signed [127:0] wide_den;
        logic signed [127:0] quot;
        if (den == 0) begin
            return 64'sd0;
        end
        wide_num = num;
        wide_den = den;
        quot = (wide_num <<< frac) / wide_den;
        if (quot > RATIO_HI) begin
            quot = RATIO_HI;
        end else if (quot < RATIO_LO) begin
            quot = RATIO_LO;
        end
        return quot[63:0];
    endfunction

    // Exact polynomial in ACC_FRAC fixed point, then round half up and clamp.
    function automatic t_pixel_fix correct_pixel(input logic signed [SAMPLE_BITS-1:0] raw,
                                                 input logic signed [63:0] sq_ratio,
                                                 input logic signed [63:0] cu_ratio);
        logic signed [255:0] wv;
        logic signed [255:0] wsq;
        logic signed [255:0] wcu;
        logic signed [255:0] acc;
        t_pixel_fix fix;
        wv  = raw;
        wsq = sq_ratio;
        wcu = cu_ratio;
        acc = (wv <<< ACC_FRAC)
            + ((wsq * wv * wv) <<< (ACC_FRAC - SQUARE_FRAC_BITS))
            + ((wcu * wv * wv * wv) <<< (ACC_FRAC - CUBE_FRAC_BITS));
        acc = (acc + (256'sd1 <<< (ACC_FRAC - 1))) >>> ACC_FRAC;
        fix.clipped = 1'b0;
        if (acc > PIX_HI) begin
            acc = PIX_HI;
            fix.clipped = 1'b1;
        end else if (acc < PIX_LO) begin
            acc = PIX_LO;
            fix.clipped = 1'b1;
        end
        fix.corrected = acc[SAMPLE_BITS-1:0];
        return fix;
    endfunction

    task automatic note_failure(input string msg);
        o_errors++;
        if (o_errors <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_clips   = 0;
        quad_ratio  = '0;
        cubic_ratio = '0;
    end

    always @(posedge i_clk) begin
        t_pixel_fix want;
        if (!i_rst_n) begin
            quad_ratio  = '0;
            cubic_ratio = '0;
            pending_fixes.delete();
            o_pending = 0;
        end else begin
            // The returned item is handled first: it always belongs to an
            // item accepted at an earlier edge.
            if (i_out_valid && i_out_ready) begin
                if (pending_fixes.size() == 0) begin
                    note_failure($sformatf("unexpected result: corrected %0d clipped %0b",
                                           i_corrected, i_clipped));
                end else begin
                    want = pending_fixes.pop_front();
                    o_pending = pending_fixes.size();
                    o_checked++;
                    if (want.clipped) begin
                        o_clips++;
                    end
                    if (i_corrected !== want.corrected || i_clipped !== want.clipped) begin
                        note_failure($sformatf(
                            "result %0d: expected corrected %0d clipped %0b, got %0d %0b",
                            o_checked, $signed(want.corrected), want.clipped,
                            i_corrected, i_clipped));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_LOAD) begin
                    quad_ratio  = fixed_ratio(i_coef_b, i_coef_a, SQUARE_FRAC_BITS);
                    cubic_ratio = fixed_ratio(i_coef_c, i_coef_a, CUBE_FRAC_BITS);
                end else begin
                    pending_fixes.push_back(correct_pixel(i_sample, quad_ratio, cubic_ratio));
                    o_pending = pending_fixes.size();
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of pixel_nonlinearity_correction_core
// Drives directed coefficient loads and samples covering the saturation,
// rounding and zero-coefficient corners, then random pixels (a load followed
// by a few samples, mixed with stray items) under three idling patterns.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import pnc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS      = 24;
    localparam int SQUARE_FRAC_BITS = 32;
    localparam int CUBE_FRAC_BITS   = 48;
    localparam int ITEM_TARGET      = 1800;
    localparam int CYCLE_LIMIT      = 1_500_000;
    localparam int DRAIN_CYCLES     = 200;

    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_BITS-1:0] PIX_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] PIX_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_cmd;
    logic signed [31:0]            i_coef_a;
    logic signed [31:0]            i_coef_b;
    logic signed [31:0]            i_coef_c;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS-1:0] o_corrected;
    logic                          o_clipped;

    int error_count;
    int pending_count;
    int checked_count;
    int clip_count;
    int send_idle;
    int recv_idle;
    int items_sent;
    int loads_sent;
    int cycle_count;

    pixel_nonlinearity_correction_core #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SQUARE_FRAC_BITS (SQUARE_FRAC_BITS),
        .CUBE_FRAC_BITS   (CUBE_FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_coef_a    (i_coef_a),
        .i_coef_b    (i_coef_b),
        .i_coef_c    (i_coef_c),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_corrected (o_corrected),
        .o_clipped   (o_clipped)
    );

    pnc_checker #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SQUARE_FRAC_BITS (SQUARE_FRAC_BITS),
        .CUBE_FRAC_BITS   (CUBE_FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_cmd       (i_cmd),
        .i_coef_a    (i_coef_a),
        .i_coef_b    (i_coef_b),
        .i_coef_c    (i_coef_c),
        .i_sample    (i_sample),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_corrected (o_corrected),
        .i_clipped   (o_clipped),
        .o_errors    (error_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count),
        .o_clips     (clip_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** pixel_nonlinearity_correction_core: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic logic signed [31:0] rand_word();
        return $urandom;
    endfunction

    // One item on the input channel; returns once it has been accepted.
    task automatic send_item(input logic cmd, input logic signed [31:0] a,
                             input logic signed [31:0] b, input logic signed [31:0] c,
                             input logic signed [SAMPLE_BITS-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid  = 1'b0;
            i_cmd    = 1'($urandom_range(0, 1));
            i_coef_a = rand_word();
            i_sample = SAMPLE_BITS'($urandom);
            @(negedge i_clk);
        end
        i_cmd    = cmd;
        i_coef_a = a;
        i_coef_b = b;
        i_coef_c = c;
        i_sample = smp;
        i_valid  = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            loads_sent++;
        end
    endtask

    task automatic send_load(input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic signed [31:0] c);
        send_item(CMD_LOAD, a, b, c, SAMPLE_BITS'($urandom));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(CMD_SAMPLE, rand_word(), rand_word(), rand_word(), smp);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] smp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: smp = SAMPLE_BITS'($urandom);
            4, 5, 6:    smp = SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
            7, 8:       smp = SAMPLE_BITS'(int'($urandom_range(0, 131072)) - 65536);
            default: begin
                case ($urandom_range(0, 4))
                    0:       smp = PIX_MAX;
                    1:       smp = PIX_MIN;
                    2:       smp = '0;
                    3:       smp = SAMPLE_BITS'(1);
                    default: smp = SAMPLE_BITS'(-1);
                endcase
            end
        endcase
        return smp;
    endfunction

    // A pixel: one coefficient load, then the samples of its planes.
    task automatic send_pixel();
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                a = rand_word();
                b = rand_word();
                c = rand_word();
            end
            5: begin
                a = '0;
                b = rand_word();
                c = rand_word();
            end
            6, 7, 8: begin
                a = int'($urandom_range(1, 16)) * ($urandom_range(0, 1) ? 1 : -1);
                b = int'($urandom_range(0, 30)) - 15;
                c = int'($urandom_range(0, 30)) - 15;
            end
            default: begin
                // Fit-like coefficients: the higher-order terms are small
                // fractions of the linear one.
                a = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
                if ($urandom_range(0, 3) == 0) begin
                    a = -a;
                end
                b = a >>> $urandom_range(6, 30);
                c = a >>> $urandom_range(14, 31);
                if ($urandom_range(0, 1)) begin
                    b = -b;
                end
                if ($urandom_range(0, 1)) begin
                    c = -c;
                end
            end
        endcase
        send_load(a, b, c);
        n = $urandom_range(1, 8);
        repeat (n) send_sample(pick_sample());
    endtask

    task automatic run_phase(input int idle_in, input int idle_out, input int item_end);
        send_idle = idle_in;
        recv_idle = idle_out;
        while (items_sent < item_end) begin
            case ($urandom_range(0, 9))
                0:       send_sample(pick_sample());
                1:       send_load(rand_word(), rand_word(), rand_word());
                default: send_pixel();
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = CMD_LOAD;
        i_coef_a    = '0;
        i_coef_b    = '0;
        i_coef_c    = '0;
        i_sample    = '0;
        i_ready     = 1'b0;
        send_idle   = 26;
        recv_idle   = 68;
        items_sent  = 0;
        loads_sent  = 0;
        cycle_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Samples before any load pass through unchanged.
        send_sample('0);
        send_sample(PIX_MAX);
        send_sample(PIX_MIN);
        send_sample(SAMPLE_BITS'(-1));
        // A zero linear coefficient clears both ratios.
        send_load('0, COEF_MAX, COEF_MIN);
        send_sample(PIX_MAX);
        send_sample(PIX_MIN);
        // A square ratio of one half gives exact halves: rounding goes up.
        send_load(4, 2, 0);
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(-1));
        send_sample(SAMPLE_BITS'(3));
        // Cube ratio overflows and saturates high.
        send_load(1, COEF_MAX, COEF_MAX);
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(-1));
        // Square ratio lands exactly on the most negative value.
        send_load(1, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_BITS'(2));
        send_sample('0);
        // Negative divisor: the square quotient overflows positive.
        send_load(-1, COEF_MIN, COEF_MAX);
        send_sample(SAMPLE_BITS'(-2));
        send_load(COEF_MIN, COEF_MAX, COEF_MIN);
        send_sample(PIX_MAX);
        send_sample(PIX_MIN);
        // Tiny ratios where truncation toward zero differs from floor.
        send_load(COEF_MAX, 1, -1);
        send_sample(PIX_MAX);
        send_sample(SAMPLE_BITS'(-5));

        run_phase(26, 68, items_sent + (ITEM_TARGET - items_sent) / 3);
        run_phase(68, 26, items_sent + (ITEM_TARGET - items_sent) / 2);
        run_phase(0, 0, ITEM_TARGET);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d items (%0d coefficient loads), checked %0d corrected samples,",
                 items_sent, loads_sent, checked_count);
        $display("%0d of them saturated; %0d failures.", clip_count, error_count);
        if (error_count == 0) begin
            $display("** pixel_nonlinearity_correction_core: PASSED **");
        end else begin
            $display("** pixel_nonlinearity_correction_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/pnc_pkg.sv
src/pnc_div.sv
src/pnc_dp.sv
src/pnc_ctrl.sv
src/pixel_nonlinearity_correction_core.sv
sim/pnc_checker.sv
sim/tb.sv
